FILE: rtl/indexed_list_insert_remove_macros.svh
// assertion macros for the indexed list block
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH

`ifndef SYNTH
// condition holds at every clock edge outside reset
`define ILIR_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("indexed list assertion failed");
// condition in one cycle implies consequence in the next
`define ILIR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed list assertion failed");
`else
`define ILIR_ASSERT_ALWAYS(lbl, cond)
`define ILIR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/ilir_pkg.sv
// shared types and codes for the indexed list block
`default_nettype none

package ilir_pkg;

   // wide enough for any supported capacity (up to 4096 entries)
   localparam int unsigned POS_BITS = 13;

   typedef logic [POS_BITS-1:0] pos_type;

   // command codes
   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_POP    = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // per-cycle control broadcast along the cell row
   typedef struct packed {
      logic    append_en;
      logic    insert_en;
      logic    remove_en;
      pos_type pos;
      pos_type tail;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/ilir_req_if.sv
// request channel of the indexed list block
`default_nettype none

interface ilir_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [6:0]  index;
   logic [31:0] element_value;

   modport source (output valid, output command, output index, output element_value,
                   input ready);
   modport sink (input valid, input command, input index, input element_value,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/ilir_rsp_if.sv
// response channel of the indexed list block
`default_nettype none

interface ilir_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] result_value;
   logic [6:0]  length;

   modport source (output valid, output status, output result_value, output length,
                   input ready);
   modport sink (input valid, input status, input result_value, input length,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/ilir_cell.sv
// one storage cell of the list row, shifts with its neighbors
`default_nettype none

module ilir_cell #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned POS   = 0
) (
   input  wire                        clock,
   input  wire ilir_pkg::cell_ctrl_type ctrl,
   input  wire  [WIDTH-1:0]           below_data,
   input  wire  [WIDTH-1:0]           above_data,
   input  wire  [WIDTH-1:0]           new_data,
   output logic [WIDTH-1:0]           data_out
);

   localparam ilir_pkg::pos_type MY_POS = ilir_pkg::pos_type'(POS);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   // pick the next word: new value, neighbor below, neighbor above or hold
   always_comb begin
      data_in = data_ff;
      if (ctrl.append_en && (MY_POS == ctrl.tail)) begin
         data_in = new_data;
      end else if (ctrl.insert_en) begin
         if (MY_POS == ctrl.pos) begin
            data_in = new_data;
         end else if (MY_POS > ctrl.pos) begin
            data_in = below_data;
         end
      end else if (ctrl.remove_en && (MY_POS >= ctrl.pos)) begin
         data_in = above_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

FILE: rtl/indexed_list_insert_remove.sv
// indexed list top level: command decode, cell row, read select, response register
// a request's response is registered and is valid the next cycle after the request is taken
// one request is taken per cycle while responses are taken; the cell row shifts
//   every later entry in parallel in that same cycle
// reset clears the entry count and the response valid; stored words are not cleared
`default_nettype none
`include "indexed_list_insert_remove_macros.svh"

module indexed_list_insert_remove #(
   parameter int unsigned CAPACITY     = 64,
   parameter int unsigned ELEMENT_BITS = 32
) (
   input wire         clock,
   input wire         reset,
   ilir_req_if.sink   req_ch,
   ilir_rsp_if.source rsp_ch
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam ilir_pkg::pos_type CAP_POS = ilir_pkg::pos_type'(CAPACITY);

   logic [CW-1:0]           count_ff;
   logic [CW-1:0]           count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [1:0]              status_ff;
   logic [1:0]              status_in;
   logic [31:0]             result_ff;
   logic [31:0]             result_in;
   logic [6:0]              length_ff;
   logic [6:0]              length_in;

   logic                    accept;
   ilir_pkg::pos_type       count_ext;
   ilir_pkg::pos_type       idx_ext;
   ilir_pkg::pos_type       rd_pos;
   ilir_pkg::pos_type       count_next;
   ilir_pkg::cell_ctrl_type ctrl;
   logic [63:0]             new_wide;
   logic [ELEMENT_BITS-1:0] new_elem;
   logic [ELEMENT_BITS-1:0] read_data;
   logic [63:0]             read_wide;
   logic [ELEMENT_BITS-1:0] cell_data [CAPACITY];

   // handshake: the response register frees up when its response is taken
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign count_ext = ilir_pkg::pos_type'(count_ff);
   assign idx_ext   = ilir_pkg::pos_type'(req_ch.index);
   assign new_wide  = 64'(req_ch.element_value);
   assign new_elem  = new_wide[ELEMENT_BITS-1:0];

   // read select: pop takes the last entry, otherwise the indexed one
   assign rd_pos = (req_ch.command == ilir_pkg::CMD_POP) ? (count_ext - 1'b1) : idx_ext;

   always_comb begin
      read_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_data = read_data
                   | (cell_data[i] & {ELEMENT_BITS{rd_pos == ilir_pkg::pos_type'(i)}});
      end
   end

   assign read_wide = 64'(read_data);

   // command decode and status
   always_comb begin
      status_in      = ilir_pkg::ST_OK;
      result_in      = '0;
      count_next     = count_ext;
      ctrl.append_en = 1'b0;
      ctrl.insert_en = 1'b0;
      ctrl.remove_en = 1'b0;
      ctrl.pos       = idx_ext;
      ctrl.tail      = count_ext;
      case (req_ch.command)
         ilir_pkg::CMD_APPEND: begin
            if (count_ext >= CAP_POS) begin
               status_in = ilir_pkg::ST_FULL;
            end else begin
               ctrl.append_en = accept;
               count_next     = count_ext + 1'b1;
            end
         end
         ilir_pkg::CMD_INSERT: begin
            if (idx_ext > count_ext) begin
               status_in = ilir_pkg::ST_BAD_INDEX;
            end else if (count_ext >= CAP_POS) begin
               status_in = ilir_pkg::ST_FULL;
            end else begin
               ctrl.insert_en = accept;
               count_next     = count_ext + 1'b1;
            end
         end
         ilir_pkg::CMD_REMOVE: begin
            if (idx_ext >= count_ext) begin
               status_in = ilir_pkg::ST_BAD_INDEX;
            end else begin
               ctrl.remove_en = accept;
               result_in      = read_wide[31:0];
               count_next     = count_ext - 1'b1;
            end
         end
         ilir_pkg::CMD_POP: begin
            if (count_ext == '0) begin
               status_in = ilir_pkg::ST_EMPTY;
            end else begin
               result_in  = read_wide[31:0];
               count_next = count_ext - 1'b1;
            end
         end
         ilir_pkg::CMD_READ: begin
            if (idx_ext >= count_ext) begin
               status_in = ilir_pkg::ST_BAD_INDEX;
            end else begin
               result_in = read_wide[31:0];
            end
         end
         default: begin
            status_in = ilir_pkg::ST_OK;
         end
      endcase
   end

   assign length_in    = count_next[6:0];
   assign count_in     = accept ? count_next[CW-1:0] : count_ff;
   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);

   // row of storage cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ELEMENT_BITS-1:0] below_w;
      logic [ELEMENT_BITS-1:0] above_w;
      if (g == 0) begin : g_first
         assign below_w = '0;
      end else begin : g_mid_lo
         assign below_w = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign above_w = '0;
      end else begin : g_mid_hi
         assign above_w = cell_data[g+1];
      end
      ilir_cell #(
         .WIDTH (ELEMENT_BITS),
         .POS   (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .below_data (below_w),
         .above_data (above_w),
         .new_data   (new_elem),
         .data_out   (cell_data[g])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         result_ff <= result_in;
         length_ff <= length_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.result_value = result_ff;
   assign rsp_ch.length       = length_ff;

   // checks
   `ILIR_ASSERT_ALWAYS(a_count_bound, ilir_pkg::pos_type'(count_ff) <= CAP_POS)
   `ILIR_ASSERT_NEXT(a_rsp_after_req, accept, rsp_valid_ff)
   `ILIR_ASSERT_NEXT(a_fail_keeps_count, accept && (status_in != ilir_pkg::ST_OK), $stable(count_ff))
   `ILIR_ASSERT_NEXT(a_append_grows, accept && ctrl.append_en, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire
